// ===== hw/rtl/lccf_pkg.sv =====
// Shared types and codes for the line counting character FIFO.
package lccf_pkg;

   localparam int unsigned CharWidth   = 8;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned CountWidth  = 8;

   localparam logic [CharWidth-1:0]  NewlineChar = 8'h0A;
   localparam logic [CountWidth-1:0] CountMax    = 8'hFF;

   typedef enum logic [1:0] {
      CMD_PUSH     = 2'd0,
      CMD_POP      = 2'd1,
      CMD_POP_LINE = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_WRITE_OK = 3'd0,
      ST_FULL     = 3'd1,
      ST_READ_OK  = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_LINE_OK  = 3'd4,
      ST_NO_LINE  = 3'd5
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // take the request transaction
      logic fetch;  // read one character and advance the read pointer
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip;        // request causes no result
      logic need_fetch;  // request reads a character before its result
      logic more;        // current line result is not the final one
   } dp_status_type;

endpackage

// ===== hw/rtl/line_counting_char_fifo_unit.sv =====
// Top level of the line counting character FIFO.
// Ring FIFO of DEPTH-1 usable byte slots that counts stored newline-terminated
// lines (saturating at 255). Commands: push (0), pop (1), pop one line (2);
// code 3 is ignored and yields no result. Every other request yields one
// result transaction, pop-line one per character through the newline or
// until the FIFO runs empty, with last set on the final one and lines_held
// giving the count after the request. A push, or any request that fails,
// goes from the idle state straight to the emit state and offers its
// result in the cycle after acceptance; a pop passes through the fetch
// state, where the character memory is read into a register, before
// emit; pop-line repeats fetch and emit for each character. The next
// request is taken back in idle. One request is in work at a time. The
// memory needs no clearing after reset: only written slots are read.
module line_counting_char_fifo_unit #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_cmd,
   input  logic [lccf_pkg::CharWidth-1:0]      req_char_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lccf_pkg::StatusWidth-1:0]    rsp_status,
   output logic [lccf_pkg::CharWidth-1:0]      rsp_char_out,
   output logic                                rsp_last,
   output logic [lccf_pkg::CountWidth-1:0]     rsp_lines_held
);

   lccf_pkg::ctrl_cmd_type  ctrl_cmd;
   lccf_pkg::dp_status_type dp_status;

   lccf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   lccf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_char_in    (req_char_in),
      .ctrl_cmd       (ctrl_cmd),
      .dp_status      (dp_status),
      .rsp_status     (rsp_status),
      .rsp_char_out   (rsp_char_out),
      .rsp_last       (rsp_last),
      .rsp_lines_held (rsp_lines_held)
   );

endmodule

// ===== hw/rtl/lccf_ctrl.sv =====
// Controller state machine that sequences requests, reads and results.
module lccf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  lccf_pkg::dp_status_type dp_status,
   output lccf_pkg::ctrl_cmd_type  ctrl_cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_FETCH = 3'b010,
      S_EMIT  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !dp_status.skip) begin
               state_in = dp_status.need_fetch ? S_FETCH : S_EMIT;
            end
         end
         S_FETCH: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               state_in = dp_status.more ? S_FETCH : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_EMIT);
   assign ctrl_cmd.load  = (state_ff == S_IDLE) && req_valid;
   assign ctrl_cmd.fetch = (state_ff == S_FETCH);

endmodule

// ===== hw/rtl/lccf_datapath.sv =====
// Datapath: character memory, ring pointers, line count and result fields.
module lccf_datapath #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          req_cmd,
   input  logic [lccf_pkg::CharWidth-1:0]      req_char_in,
   input  lccf_pkg::ctrl_cmd_type              ctrl_cmd,
   output lccf_pkg::dp_status_type             dp_status,
   output logic [lccf_pkg::StatusWidth-1:0]    rsp_status,
   output logic [lccf_pkg::CharWidth-1:0]      rsp_char_out,
   output logic                                rsp_last,
   output logic [lccf_pkg::CountWidth-1:0]     rsp_lines_held
);

   localparam int unsigned PosWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PosWidth-1:0] LastPos = PosWidth'(DEPTH - 1);

   logic [lccf_pkg::CharWidth-1:0]  mem_ff [DEPTH];
   logic [lccf_pkg::CharWidth-1:0]  rd_data_ff;
   logic [PosWidth-1:0]             wp_ff, wp_in;
   logic [PosWidth-1:0]             rp_ff, rp_in;
   logic [lccf_pkg::CountWidth-1:0] count_ff, count_in;
   lccf_pkg::status_type            status_ff, status_in;
   logic                            has_char_ff, has_char_in;
   logic                            line_mode_ff, line_mode_in;
   logic                            wr_en;
   logic [PosWidth-1:0]             wp_next;
   logic [PosWidth-1:0]             rp_next;
   logic                            empty;
   logic                            full;
   lccf_pkg::cmd_type               cmd;

   assign cmd     = lccf_pkg::cmd_type'(req_cmd);
   assign wp_next = (wp_ff == LastPos) ? '0 : wp_ff + PosWidth'(1);
   assign rp_next = (rp_ff == LastPos) ? '0 : rp_ff + PosWidth'(1);
   assign empty   = (rp_ff == wp_ff);
   assign full    = (wp_next == rp_ff);

   always_comb begin
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      has_char_in  = has_char_ff;
      line_mode_in = line_mode_ff;
      wr_en        = 1'b0;
      if (ctrl_cmd.load) begin
         has_char_in  = 1'b0;
         line_mode_in = 1'b0;
         case (cmd)
            lccf_pkg::CMD_PUSH: begin
               if (full) begin
                  status_in = lccf_pkg::ST_FULL;
               end else begin
                  status_in = lccf_pkg::ST_WRITE_OK;
                  wr_en     = 1'b1;
                  wp_in     = wp_next;
                  if (req_char_in == lccf_pkg::NewlineChar &&
                      count_ff != lccf_pkg::CountMax) begin
                     count_in = count_ff + lccf_pkg::CountWidth'(1);
                  end
               end
            end
            lccf_pkg::CMD_POP: begin
               if (empty) begin
                  status_in = lccf_pkg::ST_EMPTY;
               end else begin
                  status_in   = lccf_pkg::ST_READ_OK;
                  has_char_in = 1'b1;
               end
            end
            lccf_pkg::CMD_POP_LINE: begin
               if (empty) begin
                  status_in = lccf_pkg::ST_EMPTY;
               end else if (count_ff == '0) begin
                  status_in = lccf_pkg::ST_NO_LINE;
               end else begin
                  // drop the count up front; every line result reports it
                  status_in    = lccf_pkg::ST_LINE_OK;
                  has_char_in  = 1'b1;
                  line_mode_in = 1'b1;
                  count_in     = count_ff - lccf_pkg::CountWidth'(1);
               end
            end
            default: begin
            end
         endcase
      end
      if (ctrl_cmd.fetch) begin
         rp_in = rp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wp_ff] <= req_char_in;
      end
      if (ctrl_cmd.fetch) begin
         rd_data_ff <= mem_ff[rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         count_ff     <= '0;
         has_char_ff  <= 1'b0;
         line_mode_ff <= 1'b0;
         status_ff    <= lccf_pkg::ST_WRITE_OK;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         count_ff     <= count_in;
         has_char_ff  <= has_char_in;
         line_mode_ff <= line_mode_in;
         status_ff    <= status_in;
      end
   end

   // status toward the controller
   assign dp_status.skip       = (cmd == lccf_pkg::CMD_UNUSED);
   assign dp_status.need_fetch = !empty &&
                                 ((cmd == lccf_pkg::CMD_POP) ||
                                  ((cmd == lccf_pkg::CMD_POP_LINE) && (count_ff != '0)));
   // read pointer has already moved past the emitted character
   assign dp_status.more       = line_mode_ff && !empty &&
                                 (rd_data_ff != lccf_pkg::NewlineChar);

   assign rsp_status     = status_ff;
   assign rsp_char_out   = has_char_ff ? rd_data_ff : '0;
   assign rsp_last       = !dp_status.more;
   assign rsp_lines_held = count_ff;

endmodule

// ===== tb/line_scoreboard_pkg.sv =====
// Scoreboard class that predicts and checks line FIFO responses.
package line_scoreboard_pkg;
   import lccf_pkg::*;

   localparam int unsigned FifoDepth = 64;

   typedef struct {
      status_type            status;
      logic [CharWidth-1:0]  char_out;
      logic                  last;
      logic [CountWidth-1:0] lines_held;
   } line_result_type;

   class fifo_scoreboard;
      logic [CharWidth-1:0]  char_mem [FifoDepth];
      int unsigned           wr_ptr;
      int unsigned           rd_ptr;
      logic [CountWidth-1:0] line_cnt;
      line_result_type       pending_results [$];
      int unsigned           mismatches;

      function new();
         wr_ptr     = 0;
         rd_ptr     = 0;
         line_cnt   = '0;
         mismatches = 0;
      endfunction

      function int unsigned advance(int unsigned ptr);
         return (ptr + 1 >= FifoDepth) ? 0 : ptr + 1;
      endfunction

      function void add_result(status_type st, logic [CharWidth-1:0] ch, logic is_last);
         line_result_type r;
         r.status     = st;
         r.char_out   = ch;
         r.last       = is_last;
         r.lines_held = line_cnt;
         pending_results.push_back(r);
      endfunction

      // Update the FIFO image for one accepted transaction and queue its responses.
      function void accept_command(cmd_type cmd, logic [CharWidth-1:0] ch);
         logic [CharWidth-1:0] line_chars [$];
         logic [CharWidth-1:0] taken;
         case (cmd)
            CMD_PUSH: begin
               if (advance(wr_ptr) == rd_ptr) begin
                  add_result(ST_FULL, '0, 1'b1);
               end else begin
                  char_mem[wr_ptr] = ch;
                  wr_ptr = advance(wr_ptr);
                  if (ch == NewlineChar && line_cnt != CountMax) line_cnt++;
                  add_result(ST_WRITE_OK, '0, 1'b1);
               end
            end
            CMD_POP: begin
               if (rd_ptr == wr_ptr) begin
                  add_result(ST_EMPTY, '0, 1'b1);
               end else begin
                  add_result(ST_READ_OK, char_mem[rd_ptr], 1'b1);
                  rd_ptr = advance(rd_ptr);
               end
            end
            CMD_POP_LINE: begin
               if (rd_ptr == wr_ptr) begin
                  add_result(ST_EMPTY, '0, 1'b1);
               end else if (line_cnt == 0) begin
                  add_result(ST_NO_LINE, '0, 1'b1);
               end else begin
                  // stop at the newline, or earlier when the FIFO runs dry
                  do begin
                     taken = char_mem[rd_ptr];
                     rd_ptr = advance(rd_ptr);
                     line_chars.push_back(taken);
                  end while (taken != NewlineChar && rd_ptr != wr_ptr &&
                             line_chars.size() < FifoDepth - 1);
                  line_cnt--;
                  foreach (line_chars[k])
                     add_result(ST_LINE_OK, line_chars[k], k == line_chars.size() - 1);
               end
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string what, logic [7:0] got, logic [7:0] wanted);
         mismatches++;
         $display("%0t ns: mismatch on %s: got %h, wanted %h", $time, what, got, wanted);
      endtask

      task check_response(logic [StatusWidth-1:0] st, logic [CharWidth-1:0] ch,
                          logic is_last, logic [CountWidth-1:0] lines);
         line_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response status", 8'(st), 8'h00);
         end else begin
            want = pending_results.pop_front();
            if (st !== want.status)
               report_mismatch("status", 8'(st), 8'(want.status));
            if (ch !== want.char_out)
               report_mismatch("char_out", ch, want.char_out);
            if (is_last !== want.last)
               report_mismatch("last", 8'(is_last), 8'(want.last));
            if (lines !== want.lines_held)
               report_mismatch("lines_held", lines, want.lines_held);
         end
      endtask
   endclass

endpackage

// ===== tb/line_counting_char_fifo_unit_tb.sv =====
// Testbench top for the line counting character FIFO.
module line_counting_char_fifo_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lccf_pkg::*;
   import line_scoreboard_pkg::*;

   localparam int unsigned HoldCycles = 400;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_cmd = CMD_PUSH;
   logic [CharWidth-1:0]   req_char_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [StatusWidth-1:0] rsp_status;
   logic [CharWidth-1:0]   rsp_char_out;
   logic                   rsp_last;
   logic [CountWidth-1:0]  rsp_lines_held;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   logic        hold_request = 1'b0;
   logic        hold_off = 1'b0;

   fifo_scoreboard sb = new();

   line_counting_char_fifo_unit #(.DEPTH(FifoDepth)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_char_in    (req_char_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_char_out   (rsp_char_out),
      .rsp_last       (rsp_last),
      .rsp_lines_held (rsp_lines_held)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(negedge clock) begin
      rsp_stall = hold_off || ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_char_out, rsp_last, rsp_lines_held);
   end

   // Hold the response side off for a long stretch on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_off = 1'b1;
            repeat (HoldCycles) @(posedge clock);
            hold_off = 1'b0;
            hold_request = 1'b0;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [CharWidth-1:0] plain_char();
      logic [CharWidth-1:0] ch;
      ch = 8'($urandom_range(255));
      while (ch == NewlineChar) ch = 8'($urandom_range(255));
      return ch;
   endfunction

   task automatic send_command(cmd_type cmd, logic [CharWidth-1:0] ch);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_cmd     = cmd;
      req_char_in = ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.accept_command(cmd, ch);
      @(negedge clock);
   endtask

   task automatic push_line(int unsigned len);
      repeat (len) send_command(CMD_PUSH, plain_char());
      send_command(CMD_PUSH, NewlineChar);
   endtask

   task automatic run_random(int unsigned target);
      int unsigned sent;
      int unsigned pick;
      int unsigned len;
      cmd_type     cmd;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(62) : $urandom_range(8);
            push_line(len);
            sent += len + 1;
            if ($urandom_range(1) == 1) begin
               send_command(CMD_POP_LINE, 8'($urandom_range(255)));
               sent++;
            end
         end else if (pick < 60) begin
            send_command(CMD_POP_LINE, 8'($urandom_range(255)));
            sent++;
         end else if (pick < 70) begin
            len = $urandom_range(4, 1);
            repeat (len) send_command(CMD_POP, 8'($urandom_range(255)));
            sent += len;
         end else if (pick < 74) begin
            // overfill so that pushes bounce off a full FIFO
            repeat (66) send_command(CMD_PUSH, 8'($urandom_range(255)));
            sent += 66;
         end else if (pick < 80) begin
            // broken line: characters without a newline
            len = $urandom_range(5, 1);
            repeat (len) send_command(CMD_PUSH, plain_char());
            sent += len;
         end else begin
            cmd = cmd_type'($urandom_range(3));
            send_command(cmd, 8'($urandom_range(255)));
            if (cmd != CMD_UNUSED) sent++;
         end
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed corner cases
      send_command(CMD_POP, 8'h00);
      send_command(CMD_POP_LINE, 8'hFF);
      send_command(CMD_UNUSED, 8'h5A);
      send_command(CMD_PUSH, 8'h00);
      send_command(CMD_PUSH, 8'hFF);
      send_command(CMD_POP_LINE, 8'h00);
      send_command(CMD_PUSH, NewlineChar);
      send_command(CMD_POP_LINE, 8'h00);
      send_command(CMD_PUSH, 8'h55);
      send_command(CMD_PUSH, 8'hAA);
      send_command(CMD_PUSH, NewlineChar);
      repeat (3) send_command(CMD_POP, 8'h00);
      // count now exceeds the real lines: pop-line drains to empty
      send_command(CMD_PUSH, 8'h31);
      send_command(CMD_PUSH, 8'h32);
      send_command(CMD_POP_LINE, 8'h00);
      send_command(CMD_UNUSED, 8'hA5);
      send_command(CMD_POP_LINE, 8'h00);

      idle_pct = 0;  stall_pct = 0;  run_random(100);
      idle_pct = 88; stall_pct = 0;  run_random(100);
      idle_pct = 0;  stall_pct = 88; run_random(100);
      idle_pct = 20; stall_pct = 20; run_random(100);

      // back-pressure: responses blocked while requests keep coming
      idle_pct = 0; stall_pct = 0;
      hold_request = 1'b1;
      push_line(5);
      push_line(3);
      repeat (2) send_command(CMD_POP_LINE, 8'h00);
      push_line(10);
      repeat (3) send_command(CMD_POP_LINE, 8'h00);

      req_valid = 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lccf_pkg.sv
hw/rtl/lccf_ctrl.sv
hw/rtl/lccf_datapath.sv
hw/rtl/line_counting_char_fifo_unit.sv
tb/line_scoreboard_pkg.sv
tb/line_counting_char_fifo_unit_tb.sv
